// ===== rtl/grid_ray_dda_caster_assert.svh =====
// Assertion helpers for the checker of this block.
`ifndef GRID_RAY_DDA_CASTER_ASSERT_SVH
`define GRID_RAY_DDA_CASTER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GDC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define GDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/gdc_pkg.sv =====
`default_nettype none
package gdc_pkg;
    localparam int MAP_LOG2     = 6;
    localparam int MAP_DIM      = 1 << MAP_LOG2;
    localparam int MAP_AW       = 2 * MAP_LOG2;
    localparam int SCREEN_LOG2  = 10;
    localparam int SCREEN_WIDTH = 1 << SCREEN_LOG2;

    localparam int CELL_W  = 8;
    localparam int MAG_W   = 19;
    localparam int QUOT_W  = 33;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_MAP_W   = 3'd6;
    localparam logic [2:0] CFG_MAP_H   = 3'd7;

    typedef struct packed {
        logic              en;
        logic [MAP_AW-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_map_wr;
endpackage
`default_nettype wire

// ===== rtl/grid_ray_dda_caster.sv =====
// Cast: setup (two products, two reciprocal divisions on one shared divider,
// two first-side products), then a step and a map read per cell tested, a step
// that leaves the map if no wall is met, and a state to hand over the result.
// A write item goes straight into the map.
// One item at a time; the result waits in an output register.
// After reset the map is swept to zero; input items stall meanwhile.
`default_nettype none
module grid_ray_dda_caster (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [21:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_func,
    input  wire logic [9:0]         i_column,
    input  wire logic [5:0]         i_cell_x,
    input  wire logic [5:0]         i_cell_y,
    input  wire logic signed [7:0]  i_cell_value,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_hit,
    output logic [5:0]              o_hit_x,
    output logic [5:0]              o_hit_y,
    output logic                    o_cross_side,
    output logic [31:0]             o_side_dist_x,
    output logic [31:0]             o_side_dist_y
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MX   = 4'd1;
    localparam logic [3:0] S_MY   = 4'd2;
    localparam logic [3:0] S_DX   = 4'd3;
    localparam logic [3:0] S_WX   = 4'd4;
    localparam logic [3:0] S_WY   = 4'd5;
    localparam logic [3:0] S_FX   = 4'd6;
    localparam logic [3:0] S_FY   = 4'd7;
    localparam logic [3:0] S_FS   = 4'd8;
    localparam logic [3:0] S_STEP = 4'd9;
    localparam logic [3:0] S_CHK  = 4'd10;
    localparam logic [3:0] S_DONE = 4'd11;

    logic [3:0]          r_state, n_state;
    logic [21:0]         r_pos_x, r_pos_y;
    logic signed [17:0]  r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [6:0]          r_map_w, r_map_h;

    logic [9:0]          r_col;
    logic signed [19:0]  r_ray_x, r_ray_y;
    logic [31:0]         r_delta_x, r_delta_y, r_side_x, r_side_y;
    logic signed [7:0]   r_cx, r_cy;
    logic                r_side, r_hit;
    logic signed [50:0]  r_prod;

    logic                r_out_valid, r_o_hit, r_o_side;
    logic [5:0]          r_o_x, r_o_y;
    logic [31:0]         r_o_dx, r_o_dy;

    logic                clearing, in_acc, div_start, div_done, take_x, in_map;
    logic [31:0]         div_quot, sum_x_sat, sum_y_sat;
    logic [18:0]         div_mag;
    logic signed [17:0]  cam, mul_a;
    logic signed [32:0]  mul_b;
    logic signed [19:0]  ray_new;
    logic [16:0]         f_x, f_y;
    logic [32:0]         sum_x, sum_y;
    logic signed [7:0]   nx, ny;
    logic [6:0]          w_eff, h_eff;
    logic [7:0]          rd_data;
    gdc_pkg::t_map_wr    wr;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE) || clearing;
    assign o_cfg_ready = 1'b1;

    assign wr.en   = in_acc && !i_func;
    assign wr.addr = {i_cell_y, i_cell_x};
    assign wr.data = i_cell_value;

    // camera = 2*column*65536/SCREEN_WIDTH - 1.0
    assign cam = 18'(({11'd0, r_col, 17'd0} >> gdc_pkg::SCREEN_LOG2) - 28'sd65536);

    function automatic logic [18:0] mag(input logic signed [19:0] v);
        logic [19:0] n;
        n = v[19] ? 20'(-v) : 20'(v);
        return n[18:0];
    endfunction

    assign f_x = r_ray_x[19] ? {1'b0, r_pos_x[15:0]} : 17'h10000 - {1'b0, r_pos_x[15:0]};
    assign f_y = r_ray_y[19] ? {1'b0, r_pos_y[15:0]} : 17'h10000 - {1'b0, r_pos_y[15:0]};

    always_comb begin
        case (r_state)
            S_MX:    begin mul_a = r_plane_x; mul_b = 33'(cam); end
            S_MY:    begin mul_a = r_plane_y; mul_b = 33'(cam); end
            S_FX:    begin mul_a = {1'b0, f_x}; mul_b = {1'b0, r_delta_x}; end
            S_FY:    begin mul_a = {1'b0, f_y}; mul_b = {1'b0, r_delta_y}; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // floor(plane*cam / 65536) added to the direction
    assign ray_new = 20'(r_prod[35:16]) + 20'(r_state == S_MY ? r_dir_x : r_dir_y);

    assign div_start = (r_state == S_DX) || (r_state == S_WX && div_done);
    assign div_mag   = (r_state == S_DX) ? mag(r_ray_x) : mag(r_ray_y);

    gdc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (div_mag),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // stepping
    assign take_x    = r_side_x < r_side_y;
    assign sum_x     = {1'b0, r_side_x} + {1'b0, r_delta_x};
    assign sum_y     = {1'b0, r_side_y} + {1'b0, r_delta_y};
    assign sum_x_sat = sum_x[32] ? 32'hFFFF_FFFF : sum_x[31:0];
    assign sum_y_sat = sum_y[32] ? 32'hFFFF_FFFF : sum_y[31:0];
    assign nx = take_x ? (r_ray_x[19] ? r_cx - 8'sd1 : r_cx + 8'sd1) : r_cx;
    assign ny = take_x ? r_cy : (r_ray_y[19] ? r_cy - 8'sd1 : r_cy + 8'sd1);
    assign w_eff = (r_map_w > 7'(gdc_pkg::MAP_DIM)) ? 7'(gdc_pkg::MAP_DIM) : r_map_w;
    assign h_eff = (r_map_h > 7'(gdc_pkg::MAP_DIM)) ? 7'(gdc_pkg::MAP_DIM) : r_map_h;
    assign in_map = !nx[7] && !ny[7] && ({1'b0, nx[6:0]} < {1'b0, w_eff})
                    && ({1'b0, ny[6:0]} < {1'b0, h_eff});

    gdc_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr),
        .i_rd_addr  ({ny[5:0], nx[5:0]}),
        .o_rd_data  (rd_data),
        .o_clearing (clearing)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc && i_func) n_state = S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_DX;
            S_DX:   n_state = S_WX;
            S_WX:   if (div_done) n_state = S_WY;
            S_WY:   if (div_done) n_state = S_FX;
            S_FX:   n_state = S_FY;
            S_FY:   n_state = S_FS;
            S_FS:   n_state = S_STEP;
            S_STEP: n_state = in_map ? S_CHK : S_DONE;
            S_CHK:  n_state = ($signed(rd_data) > 8'sd0) ? S_DONE : S_STEP;
            S_DONE: if (!r_out_valid || !i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pos_x     <= 22'd65536;
            r_pos_y     <= 22'd65536;
            r_dir_x     <= 18'sd65536;
            r_dir_y     <= 18'sd0;
            r_plane_x   <= 18'sd0;
            r_plane_y   <= 18'sd43254;
            r_map_w     <= 7'd64;
            r_map_h     <= 7'd64;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall))
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    gdc_pkg::CFG_POS_X:   r_pos_x   <= i_cfg_data;
                    gdc_pkg::CFG_POS_Y:   r_pos_y   <= i_cfg_data;
                    gdc_pkg::CFG_DIR_X:   r_dir_x   <= i_cfg_data[17:0];
                    gdc_pkg::CFG_DIR_Y:   r_dir_y   <= i_cfg_data[17:0];
                    gdc_pkg::CFG_PLANE_X: r_plane_x <= i_cfg_data[17:0];
                    gdc_pkg::CFG_PLANE_Y: r_plane_y <= i_cfg_data[17:0];
                    gdc_pkg::CFG_MAP_W:   r_map_w   <= i_cfg_data[6:0];
                    gdc_pkg::CFG_MAP_H:   r_map_h   <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                r_col <= i_column;
                r_cx  <= {2'b00, r_pos_x[21:16]};
                r_cy  <= {2'b00, r_pos_y[21:16]};
            end
            S_MY: r_ray_x <= ray_new;
            S_DX: r_ray_y <= ray_new;
            S_WX: if (div_done) r_delta_x <= div_quot;
            S_WY: if (div_done) r_delta_y <= div_quot;
            S_FY: r_side_x <= r_prod[48] ? 32'hFFFF_FFFF : r_prod[47:16];
            S_FS: r_side_y <= r_prod[48] ? 32'hFFFF_FFFF : r_prod[47:16];
            S_STEP: begin
                r_cx   <= nx;
                r_cy   <= ny;
                r_side <= !take_x;
                r_hit  <= 1'b0;
                if (take_x) r_side_x <= sum_x_sat;
                else        r_side_y <= sum_y_sat;
            end
            S_CHK: r_hit <= $signed(rd_data) > 8'sd0;
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_o_hit  <= r_hit;
                    r_o_side <= r_side;
                    r_o_x    <= r_cx[5:0];
                    r_o_y    <= r_cy[5:0];
                    r_o_dx   <= r_side_x;
                    r_o_dy   <= r_side_y;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_o_hit;
    assign o_hit_x       = r_o_x;
    assign o_hit_y       = r_o_y;
    assign o_cross_side  = r_o_side;
    assign o_side_dist_x = r_o_dx;
    assign o_side_dist_y = r_o_dy;
endmodule
`default_nettype wire

// ===== rtl/gdc_div.sv =====
`default_nettype none
// Restoring divider: 2^32 / divisor, one quotient bit per cycle, saturated.
module gdc_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [gdc_pkg::MAG_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [31:0]                    o_quot
);
    logic                           r_busy, r_done;
    logic [5:0]                     r_cnt;
    logic [gdc_pkg::MAG_W:0]        r_rem;
    logic [gdc_pkg::QUOT_W-1:0]     r_quot;
    logic [gdc_pkg::MAG_W-1:0]      r_div;
    logic [gdc_pkg::MAG_W:0]        shifted;
    logic                           ge;

    // dividend is a single one followed by 32 zeros
    assign shifted = {r_rem[gdc_pkg::MAG_W-1:0], (r_cnt == 6'd0)};
    assign ge      = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(gdc_pkg::QUOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? shifted - {1'b0, r_div} : shifted;
            r_quot <= {r_quot[gdc_pkg::QUOT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[gdc_pkg::QUOT_W-1] ? 32'hFFFF_FFFF : r_quot[31:0];
endmodule
`default_nettype wire

// ===== rtl/gdc_map.sv =====
`default_nettype none
// Map store with a zeroing sweep after reset.
module gdc_map (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire gdc_pkg::t_map_wr           i_wr,
    input  wire logic [gdc_pkg::MAP_AW-1:0] i_rd_addr,
    output logic [gdc_pkg::CELL_W-1:0]      o_rd_data,
    output logic                            o_clearing
);
    logic [gdc_pkg::CELL_W-1:0] mem [gdc_pkg::MAP_DIM*gdc_pkg::MAP_DIM];
    logic [gdc_pkg::MAP_AW:0]   r_clr_cnt;
    logic                       r_clearing;
    logic [gdc_pkg::CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt[gdc_pkg::MAP_AW-1:0] == '1)
                r_clearing <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing)
            mem[r_clr_cnt[gdc_pkg::MAP_AW-1:0]] <= '0;
        else if (i_wr.en)
            mem[i_wr.addr] <= i_wr.data;
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;
endmodule
`default_nettype wire

// ===== rtl/gdc_checker.sv =====
`default_nettype none
`include "grid_ray_dda_caster_assert.svh"
module gdc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_stall,
    input wire logic        i_func,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [31:0] o_side_dist_x
);
    `GDC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `GDC_ASSERT_NEXT(a_dist_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_side_dist_x))
    `GDC_ASSERT_NEXT(a_cast_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && i_func, o_in_stall)
    `GDC_ASSERT_NEXT(a_write_silent, i_clk, i_rst_n, i_in_valid && !o_in_stall && !i_func && !o_out_valid, !o_out_valid)
endmodule

bind grid_ray_dda_caster gdc_checker u_gdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_func        (i_func),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_side_dist_x (o_side_dist_x)
);
`default_nettype wire

// ===== tb/sv/grid_ray_dda_caster_checker.sv =====
`default_nettype none
module grid_ray_dda_caster_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [21:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_stall,
    input  wire logic               i_func,
    input  wire logic [9:0]         i_column,
    input  wire logic [5:0]         i_cell_x,
    input  wire logic [5:0]         i_cell_y,
    input  wire logic [7:0]         i_cell_value,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_hit,
    input  wire logic [5:0]         i_hit_x,
    input  wire logic [5:0]         i_hit_y,
    input  wire logic               i_cross_side,
    input  wire logic [31:0]        i_side_dist_x,
    input  wire logic [31:0]        i_side_dist_y,
    output int                      o_errors,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT = 64'hFFFF_FFFF;

    typedef struct {
        logic        hit;
        logic [5:0]  hx;
        logic [5:0]  hy;
        logic        side;
        logic [31:0] sdx;
        logic [31:0] sdy;
    } t_cast;

    logic [21:0]        pos_x, pos_y;
    logic signed [17:0] dir_x, dir_y, plane_x, plane_y;
    logic [6:0]         map_w, map_h;
    logic signed [7:0]  cells [gdc_pkg::MAP_DIM*gdc_pkg::MAP_DIM];
    t_cast              casts_due [$];

    assign o_pending = casts_due.size();

    function automatic longint recip(longint r);
        longint a;
        longint q;
        if (r == 0) return SAT;
        a = (r < 0) ? -r : r;
        q = (64'd1 << 32) / a;
        return (q > SAT) ? SAT : q;
    endfunction

    function automatic longint first_side(logic [21:0] p, bit neg, longint d);
        longint fr;
        longint v;
        fr = p[15:0];
        if (!neg) fr = 65536 - fr;
        v = (fr * d) >> 16;
        return (v > SAT) ? SAT : v;
    endfunction

    function automatic longint sat_add(longint a, longint b);
        return (a + b > SAT) ? SAT : a + b;
    endfunction

    function automatic t_cast cast_ray(logic [9:0] col);
        t_cast  r;
        longint cam, rx, ry, dx, dy, ax, ay;
        int     cx, cy, sx, sy, w, h;
        bit     in_map;
        cam = (longint'(col) * 2 * 65536) / gdc_pkg::SCREEN_WIDTH - 65536;
        rx = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 16);
        ry = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 16);
        cx = pos_x[21:16];
        cy = pos_y[21:16];
        dx = recip(rx);
        dy = recip(ry);
        ax = first_side(pos_x, rx < 0, dx);
        ay = first_side(pos_y, ry < 0, dy);
        sx = (rx < 0) ? -1 : 1;
        sy = (ry < 0) ? -1 : 1;
        w = (map_w > gdc_pkg::MAP_DIM) ? gdc_pkg::MAP_DIM : map_w;
        h = (map_h > gdc_pkg::MAP_DIM) ? gdc_pkg::MAP_DIM : map_h;
        r.hit = 0;
        r.side = 0;
        forever begin
            if (ax < ay) begin
                ax = sat_add(ax, dx);
                cx += sx;
                r.side = 0;
            end else begin
                ay = sat_add(ay, dy);
                cy += sy;
                r.side = 1;
            end
            in_map = cx >= 0 && cx < w && cy >= 0 && cy < h;
            if (!in_map) break;
            if (cells[cy*gdc_pkg::MAP_DIM + cx] > 0) begin
                r.hit = 1;
                break;
            end
        end
        r.hx = cx[5:0];
        r.hy = cy[5:0];
        r.sdx = ax[31:0];
        r.sdy = ay[31:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
    end

    always @(posedge i_clk) begin
        t_cast e;
        if (!i_rst_n) begin
            pos_x <= 22'd65536;
            pos_y <= 22'd65536;
            dir_x <= 18'sd65536;
            dir_y <= 18'sd0;
            plane_x <= 18'sd0;
            plane_y <= 18'sd43254;
            map_w <= 7'd64;
            map_h <= 7'd64;
            foreach (cells[i]) cells[i] = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (casts_due.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    e = casts_due.pop_front();
                    if (i_hit !== e.hit) report_mismatch("hit", i_hit, e.hit);
                    if (i_hit_x !== e.hx) report_mismatch("hit_x", i_hit_x, e.hx);
                    if (i_hit_y !== e.hy) report_mismatch("hit_y", i_hit_y, e.hy);
                    if (i_cross_side !== e.side)
                        report_mismatch("cross_side", i_cross_side, e.side);
                    if (i_side_dist_x !== e.sdx)
                        report_mismatch("side_dist_x", i_side_dist_x, e.sdx);
                    if (i_side_dist_y !== e.sdy)
                        report_mismatch("side_dist_y", i_side_dist_y, e.sdy);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    gdc_pkg::CFG_POS_X:   pos_x <= i_cfg_data;
                    gdc_pkg::CFG_POS_Y:   pos_y <= i_cfg_data;
                    gdc_pkg::CFG_DIR_X:   dir_x <= i_cfg_data[17:0];
                    gdc_pkg::CFG_DIR_Y:   dir_y <= i_cfg_data[17:0];
                    gdc_pkg::CFG_PLANE_X: plane_x <= i_cfg_data[17:0];
                    gdc_pkg::CFG_PLANE_Y: plane_y <= i_cfg_data[17:0];
                    gdc_pkg::CFG_MAP_W:   map_w <= i_cfg_data[6:0];
                    gdc_pkg::CFG_MAP_H:   map_h <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func) casts_due.push_back(cast_ray(i_column));
                else cells[i_cell_y*gdc_pkg::MAP_DIM + i_cell_x] = i_cell_value;
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/grid_ray_dda_caster_tb.sv =====
`default_nettype none
module grid_ray_dda_caster_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 40000;

    logic        i_clk, i_rst_n;
    logic        i_cfg_valid, o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [21:0] i_cfg_data;
    logic        i_in_valid, o_in_stall;
    logic        i_func;
    logic [9:0]  i_column;
    logic [5:0]  i_cell_x, i_cell_y;
    logic signed [7:0] i_cell_value;
    logic        o_out_valid, i_out_stall;
    logic        o_hit, o_cross_side;
    logic [5:0]  o_hit_x, o_hit_y;
    logic [31:0] o_side_dist_x, o_side_dist_y;
    int          errors, casts_pending;
    int          idle_pct;
    int          quiet_cycles;

    grid_ray_dda_caster DUT (.*);

    grid_ray_dda_caster_checker u_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_func, .i_column,
        .i_cell_x, .i_cell_y, .i_cell_value,
        .i_out_valid(o_out_valid), .i_out_stall, .i_hit(o_hit),
        .i_hit_x(o_hit_x), .i_hit_y(o_hit_y), .i_cross_side(o_cross_side),
        .i_side_dist_x(o_side_dist_x), .i_side_dist_y(o_side_dist_y),
        .o_errors(errors), .o_pending(casts_pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver backpressure
    always @(negedge i_clk) i_out_stall <= ($urandom_range(99) < idle_pct);

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(logic [2:0] idx, logic [21:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
    endtask

    task automatic send(logic f, logic [9:0] col, logic [5:0] cx, logic [5:0] cy,
                        logic [7:0] v);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 0;
            @(negedge i_clk);
        end
        i_func <= f;
        i_column <= col;
        i_cell_x <= cx;
        i_cell_y <= cy;
        i_cell_value <= v;
        i_in_valid <= 1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 0;
        while (casts_pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_view(logic [21:0] px, logic [21:0] py, logic [17:0] dx,
                            logic [17:0] dy, logic [17:0] plx, logic [17:0] ply,
                            logic [6:0] w, logic [6:0] h);
        drain();
        write_reg(gdc_pkg::CFG_POS_X, px);
        write_reg(gdc_pkg::CFG_POS_Y, py);
        write_reg(gdc_pkg::CFG_DIR_X, {4'b0, dx});
        write_reg(gdc_pkg::CFG_DIR_Y, {4'b0, dy});
        write_reg(gdc_pkg::CFG_PLANE_X, {4'b0, plx});
        write_reg(gdc_pkg::CFG_PLANE_Y, {4'b0, ply});
        write_reg(gdc_pkg::CFG_MAP_W, {15'b0, w});
        write_reg(gdc_pkg::CFG_MAP_H, {15'b0, h});
        i_cfg_valid <= 0;
    endtask

    function automatic logic [6:0] pick_dim();
        case ($urandom_range(9))
            0: return 7'($urandom_range(1));
            1: return 7'($urandom_range(127, 65));
            2: return 7'd64;
            default: return 7'($urandom_range(16, 2));
        endcase
    endfunction

    initial begin
        logic [6:0] w, h;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_index = 0;
        i_cfg_data = 0;
        i_in_valid = 0;
        i_func = 0;
        i_column = 0;
        i_cell_x = 0;
        i_cell_y = 0;
        i_cell_value = 0;
        i_out_stall = 0;
        idle_pct = 22;
        quiet_cycles = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset view, walls, extreme columns
        send(1, 10'd512, 0, 0, 0);
        send(0, 0, 6'd5, 6'd1, 8'sd127);
        send(0, 0, 6'd63, 6'd63, 8'sh80);
        send(0, 0, 6'd3, 6'd0, 8'sd0);
        send(1, 10'd0, 0, 0, 0);
        send(1, 10'd1023, 0, 0, 0);
        send(1, 10'd512, 0, 0, 0);
        // zero x ray, pos at cell 0 edge, small map
        set_view(22'd0, 22'd32768, 18'd0, 18'h20000, 18'd0, 18'h1FFFF, 7'd4, 7'd4);
        send(0, 0, 6'd0, 6'd2, 8'sd1);
        send(1, 10'd512, 0, 0, 0);
        send(1, 10'd0, 0, 0, 0);
        send(1, 10'd1023, 0, 0, 0);
        // max pos, extreme direction, oversize map
        set_view(22'h3FFFFF, 22'h3FFFFF, 18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000,
                 7'd127, 7'd127);
        send(1, 10'd0, 0, 0, 0);
        send(1, 10'd1023, 0, 0, 0);
        send(1, 10'd700, 0, 0, 0);
        // empty map, equal side distances on a diagonal
        set_view(22'h18000, 22'h18000, 18'd65536, 18'd65536, 18'd0, 18'd0, 7'd0, 7'd0);
        send(1, 10'd100, 0, 0, 0);
        set_view(22'h18000, 22'h18000, 18'd65536, 18'd65536, 18'd0, 18'd0, 7'd1, 7'd2);
        send(1, 10'd100, 0, 0, 0);
        // sender holds off until every result is back
        drain();
        send(1, 10'd300, 0, 0, 0);

        for (int ph = 0; ph < 12; ph++) begin
            w = pick_dim();
            h = pick_dim();
            set_view(22'($urandom_range((w > 64 ? 64 : (w == 0 ? 1 : w)) * 65536 - 1)),
                     22'($urandom_range((h > 64 ? 64 : (h == 0 ? 1 : h)) * 65536 - 1)),
                     18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom), w, h);
            idle_pct = (ph == 5) ? 0 : 22;
            for (int n = 0; n < 62; n++) begin
                if ($urandom_range(99) < 35)
                    send(0, 10'($urandom),
                         6'($urandom_range(w < 8 ? 7 : 63)),
                         6'($urandom_range(h < 8 ? 7 : 63)), 8'($urandom));
                else
                    send(1, 10'($urandom), 6'($urandom), 6'($urandom), 8'($urandom));
            end
        end

        drain();
        repeat (400) @(negedge i_clk);
        if (errors == 0 && casts_pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/gdc_pkg.sv
rtl/gdc_div.sv
rtl/gdc_map.sv
rtl/grid_ray_dda_caster.sv
rtl/gdc_checker.sv
tb/sv/grid_ray_dda_caster_checker.sv
tb/sv/grid_ray_dda_caster_tb.sv
